[design/fau_pkg.sv]
// ----------------------------------------------------------------------------
// fau_pkg
// Shared widths, request codes and accumulator bank control for the feature
// accumulator update block.
// ----------------------------------------------------------------------------
package fau_pkg;

   localparam int NEURONS_DEF  = 32;
   localparam int FEATURES_DEF = 1024;

   localparam int REQ_TYPE_W = 3;
   localparam int FEATURE_W  = 10;
   localparam int NEURON_W   = 5;
   localparam int WEIGHT_W   = 8;
   localparam int SUM_W      = 32;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_WR_WEIGHT = 3'd0,
      REQ_WR_BIAS   = 3'd1,
      REQ_REFRESH   = 3'd2,
      REQ_ADD       = 3'd3,
      REQ_REMOVE    = 3'd4,
      REQ_READ      = 3'd5
   } req_kind_type;

   typedef enum logic [1:0] {
      ACC_LOAD = 2'd0,
      ACC_ADD  = 2'd1,
      ACC_SUB  = 2'd2
   } acc_op_type;

   typedef struct packed {
      logic       rd_en;
      logic       wr_en;
      acc_op_type op;
   } fau_acc_ctl_type;

endpackage

[design/fau_req_if.sv]
// ----------------------------------------------------------------------------
// fau_req_if
// Request channel: one word per operation on the accumulator.
// ----------------------------------------------------------------------------
interface fau_req_if import fau_pkg::*;;
   logic                        valid;
   logic                        ready;
   logic [REQ_TYPE_W-1:0]       req_type;
   logic [FEATURE_W-1:0]        feature_index;
   logic [NEURON_W-1:0]         neuron_index;
   logic signed [WEIGHT_W-1:0]  weight_value;
   logic signed [SUM_W-1:0]     bias_value;

   modport source (
      output valid, req_type, feature_index, neuron_index, weight_value, bias_value,
      input  ready
   );
   modport sink (
      input  valid, req_type, feature_index, neuron_index, weight_value, bias_value,
      output ready
   );
endinterface

[design/fau_rsp_if.sv]
// ----------------------------------------------------------------------------
// fau_rsp_if
// Response channel: one word per read of an accumulator entry.
// ----------------------------------------------------------------------------
interface fau_rsp_if import fau_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [NEURON_W-1:0]      read_neuron;
   logic signed [SUM_W-1:0]  sum_value;

   modport source (
      output valid, read_neuron, sum_value,
      input  ready
   );
   modport sink (
      input  valid, read_neuron, sum_value,
      output ready
   );
endinterface

[design/fau_acc_bank.sv]
// ----------------------------------------------------------------------------
// fau_acc_bank
// Accumulator memory with registered read and a read-modify-write adder on
// the write port. Add and subtract combine the operand with the word read in
// the previous cycle; a load writes the operand unchanged.
// ----------------------------------------------------------------------------
module fau_acc_bank import fau_pkg::*; #(
   parameter  int NEURONS = NEURONS_DEF,
   localparam int NW      = (NEURONS > 1) ? $clog2(NEURONS) : 1
) (
   input  logic                   clock,
   input  fau_acc_ctl_type        ctl,
   input  logic [NW-1:0]          rd_addr,
   input  logic [NW-1:0]          wr_addr,
   input  logic [SUM_W-1:0]       operand,
   output logic [SUM_W-1:0]       rd_data
);

   logic [SUM_W-1:0] mem [NEURONS];
   logic [SUM_W-1:0] rd_data_ff;
   logic [SUM_W-1:0] wr_data_in;

   always_comb begin
      case (ctl.op)
         ACC_LOAD: wr_data_in = operand;
         ACC_ADD:  wr_data_in = rd_data_ff + operand;
         ACC_SUB:  wr_data_in = rd_data_ff - operand;
         default:  wr_data_in = operand;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data_in;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/feature_accumulator_update.sv]
// ----------------------------------------------------------------------------
// feature_accumulator_update
// Weight table, bias vector and accumulator vector of an incrementally
// updated first network layer. Add, remove and refresh walk the accumulator
// one neuron per cycle; add and remove do a read-modify-write on its memory.
//
//   channel   dir   handshake      word
//   req_port  in    valid/ready    req_type, feature_index, neuron_index,
//                                  weight_value, bias_value
//   rsp_port  out   valid/ready    read_neuron, sum_value
//
// Weight and bias writes are done in the cycle they are accepted. Refresh,
// and add and remove of a feature in range, are accepted, walk all NEURONS
// entries through the single accumulator write port, then do the last write-back.
// A read fetches the entry, then waits for rsp_port to drain its register.
// After reset a clearing pass zeroes the accumulator; req_port.ready stays low
// until the clearing pass has done its last write.
// A stalled response holds its register; the next request is taken meanwhile.
// ----------------------------------------------------------------------------
module feature_accumulator_update import fau_pkg::*; #(
   parameter int NEURONS  = NEURONS_DEF,
   parameter int FEATURES = FEATURES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   fau_req_if.sink      req_port,
   fau_rsp_if.source    rsp_port
);

   localparam int NW      = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam int WDEPTH  = FEATURES * NEURONS;
   localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_FETCH
   } state_type;

   state_type           state_ff, state_in;
   logic [NW-1:0]       j_ff, j_in;
   logic [WADDR_W-1:0]  base_ff, base_in;
   acc_op_type          walk_op_ff, walk_op_in;
   logic                wb_valid_ff, wb_valid_in;
   logic [NW-1:0]       wb_addr_ff, wb_addr_in;
   acc_op_type          wb_op_ff, wb_op_in;
   logic                wb_zero_ff, wb_zero_in;
   logic [NEURON_W-1:0] read_neuron_ff, read_neuron_in;
   logic                read_ok_ff, read_ok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [NEURON_W-1:0] rsp_neuron_ff, rsp_neuron_in;
   logic [SUM_W-1:0]    rsp_sum_ff, rsp_sum_in;

   logic [WEIGHT_W-1:0] weight_mem [WDEPTH];
   logic [WEIGHT_W-1:0] weight_rd_ff;
   logic [SUM_W-1:0]    bias_mem [NEURONS];
   logic [SUM_W-1:0]    bias_rd_ff;

   logic                accept;
   logic                feature_ok;
   logic                neuron_ok;
   logic                last;
   req_kind_type        kind;
   logic [WADDR_W-1:0]  weight_wr_addr;
   logic [WADDR_W-1:0]  weight_rd_addr;
   logic [WADDR_W-1:0]  row_base;
   logic                weight_wr_en;
   logic                weight_rd_en;
   logic                bias_wr_en;
   logic                bias_rd_en;
   logic                acc_rd_en;
   fau_acc_ctl_type     acc_ctl;
   logic [NW-1:0]       acc_rd_addr;
   logic [SUM_W-1:0]    acc_operand;
   logic [SUM_W-1:0]    acc_rd_data;

   assign req_port.ready = (state_ff == ST_IDLE) && !wb_valid_ff;
   assign accept         = req_port.valid && req_port.ready;
   assign kind           = req_kind_type'(req_port.req_type);
   assign feature_ok     = 32'(req_port.feature_index) < 32'(FEATURES);
   assign neuron_ok      = 32'(req_port.neuron_index) < 32'(NEURONS);
   assign last           = (j_ff == NW'(NEURONS - 1));
   assign row_base       = WADDR_W'(32'(req_port.feature_index) * 32'(NEURONS));
   assign weight_wr_addr = row_base + WADDR_W'(req_port.neuron_index);
   assign weight_rd_addr = base_ff + WADDR_W'(j_ff);

   always_comb begin
      state_in       = state_ff;
      j_in           = j_ff;
      base_in        = base_ff;
      walk_op_in     = walk_op_ff;
      wb_valid_in    = 1'b0;
      wb_addr_in     = j_ff;
      wb_op_in       = walk_op_ff;
      wb_zero_in     = 1'b0;
      read_neuron_in = read_neuron_ff;
      read_ok_in     = read_ok_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_port.ready;
      rsp_neuron_in  = rsp_neuron_ff;
      rsp_sum_in     = rsp_sum_ff;
      acc_rd_en      = 1'b0;
      acc_rd_addr    = j_ff;
      weight_wr_en   = 1'b0;
      weight_rd_en   = 1'b0;
      bias_wr_en     = 1'b0;
      bias_rd_en     = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            wb_valid_in = 1'b1;
            wb_op_in    = ACC_LOAD;
            wb_zero_in  = 1'b1;
            if (last) begin
               j_in     = '0;
               state_in = ST_IDLE;
            end else begin
               j_in = j_ff + NW'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (kind) inside
                  REQ_WR_WEIGHT: begin
                     weight_wr_en = feature_ok && neuron_ok;
                  end
                  REQ_WR_BIAS: begin
                     bias_wr_en = neuron_ok;
                  end
                  REQ_REFRESH: begin
                     walk_op_in = ACC_LOAD;
                     j_in       = '0;
                     state_in   = ST_WALK;
                  end
                  REQ_ADD, REQ_REMOVE: begin
                     if (feature_ok) begin
                        walk_op_in = (kind == REQ_ADD) ? ACC_ADD : ACC_SUB;
                        base_in    = row_base;
                        j_in       = '0;
                        state_in   = ST_WALK;
                     end
                  end
                  REQ_READ: begin
                     acc_rd_en      = 1'b1;
                     acc_rd_addr    = NW'(req_port.neuron_index);
                     read_neuron_in = req_port.neuron_index;
                     read_ok_in     = neuron_ok;
                     state_in       = ST_FETCH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            acc_rd_en     = 1'b1;
            weight_rd_en  = (walk_op_ff != ACC_LOAD);
            bias_rd_en    = (walk_op_ff == ACC_LOAD);
            wb_valid_in   = 1'b1;
            if (last) begin
               j_in     = '0;
               state_in = ST_IDLE;
            end else begin
               j_in = j_ff + NW'(1);
            end
         end
         ST_FETCH: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_neuron_in = read_neuron_ff;
               rsp_sum_in    = read_ok_ff ? acc_rd_data : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         j_ff         <= '0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         j_ff           <= j_in;
         base_ff        <= base_in;
         walk_op_ff     <= walk_op_in;
         wb_valid_ff    <= wb_valid_in;
         wb_addr_ff     <= wb_addr_in;
         wb_op_ff       <= wb_op_in;
         wb_zero_ff     <= wb_zero_in;
         read_neuron_ff <= read_neuron_in;
         read_ok_ff     <= read_ok_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_neuron_ff  <= rsp_neuron_in;
         rsp_sum_ff     <= rsp_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (weight_wr_en) begin
         weight_mem[weight_wr_addr] <= req_port.weight_value;
      end
      if (weight_rd_en) begin
         weight_rd_ff <= weight_mem[weight_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (bias_wr_en) begin
         bias_mem[NW'(req_port.neuron_index)] <= req_port.bias_value;
      end
      if (bias_rd_en) begin
         bias_rd_ff <= bias_mem[j_ff];
      end
   end

   always_comb begin
      acc_ctl.rd_en = acc_rd_en;
      acc_ctl.wr_en = wb_valid_ff;
      acc_ctl.op    = wb_op_ff;
      if (wb_op_ff == ACC_LOAD) begin
         acc_operand = wb_zero_ff ? '0 : bias_rd_ff;
      end else begin
         acc_operand = {{(SUM_W - WEIGHT_W){weight_rd_ff[WEIGHT_W-1]}}, weight_rd_ff};
      end
   end

   fau_acc_bank #(
      .NEURONS (NEURONS)
   ) u_acc_bank (
      .clock   (clock),
      .ctl     (acc_ctl),
      .rd_addr (acc_rd_addr),
      .wr_addr (wb_addr_ff),
      .operand (acc_operand),
      .rd_data (acc_rd_data)
   );

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.read_neuron = rsp_neuron_ff;
   assign rsp_port.sum_value   = rsp_sum_ff;

endmodule

[sim/feature_accumulator_update_tb.sv]
// ----------------------------------------------------------------------------
// feature_accumulator_update_tb
// Loads all biases and two full weight rows, then walks a table of directed
// words (reads after reset, extreme weights and biases, wrapping sums, unused
// request codes) and about eighteen hundred random words built mostly from
// full weight rows, adds, removes, refreshes and reads. Every accepted request
// updates a local copy of the weight, bias and sum stores; each read result
// is checked against the oldest predicted sum.
// ----------------------------------------------------------------------------
module feature_accumulator_update_tb import fau_pkg::*;;

   localparam int NEURONS       = NEURONS_DEF;
   localparam int FEATURES      = FEATURES_DEF;
   localparam int RANDOM_ITEMS  = 1750;
   localparam int PAUSE_EVERY   = 400;
   localparam int WATCHDOG      = 1000;
   localparam int DIRECTED_ROWS = 23;

   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_6 = 3'd6;
   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0]      kind;
      logic [FEATURE_W-1:0]       feature;
      logic [NEURON_W-1:0]        neuron;
      logic signed [WEIGHT_W-1:0] weight;
      logic signed [SUM_W-1:0]    bias;
      logic                       fixed_sum;
      logic signed [SUM_W-1:0]    sum;
   } op_word_type;

   typedef struct packed {
      logic [NEURON_W-1:0]     neuron;
      logic signed [SUM_W-1:0] sum;
   } read_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fau_req_if req_bus ();
   fau_rsp_if rsp_bus ();

   feature_accumulator_update dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   always #2 clock = ~clock;

   op_word_type cur_word  = '0;
   logic        req_valid = 1'b0;
   logic        rsp_ready = 1'b0;

   assign req_bus.valid         = req_valid;
   assign req_bus.req_type      = cur_word.kind;
   assign req_bus.feature_index = cur_word.feature;
   assign req_bus.neuron_index  = cur_word.neuron;
   assign req_bus.weight_value  = cur_word.weight;
   assign req_bus.bias_value    = cur_word.bias;
   assign rsp_bus.ready         = rsp_ready;

   op_word_type directed_ops [DIRECTED_ROWS] = '{
      '{REQ_READ,      10'd0,    5'd0,  8'sd0,   32'sd0,        1'b1, 32'sd0},
      '{REQ_READ,      10'd0,    5'd31, 8'sd0,   32'sd0,        1'b1, 32'sd0},
      '{REQ_SPARE_6,   10'd1023, 5'd31, 8'shff,  32'shffffffff, 1'b0, 32'sd0},
      '{REQ_SPARE_7,   10'd1023, 5'd0,  8'sh80,  32'sh7fffffff, 1'b0, 32'sd0},
      '{REQ_READ,      10'd0,    5'd31, 8'sd0,   32'sd0,        1'b1, 32'sd0},
      '{REQ_WR_BIAS,   10'd0,    5'd0,  8'sd0,   32'sh7fffffff, 1'b0, 32'sd0},
      '{REQ_WR_BIAS,   10'd0,    5'd31, 8'sd0,   32'sh80000000, 1'b0, 32'sd0},
      '{REQ_WR_WEIGHT, 10'd0,    5'd0,  8'sh7f,  32'sd0,        1'b0, 32'sd0},
      '{REQ_WR_WEIGHT, 10'd1023, 5'd31, 8'sh80,  32'sd0,        1'b0, 32'sd0},
      '{REQ_WR_WEIGHT, 10'd0,    5'd31, 8'sh80,  32'sd0,        1'b0, 32'sd0},
      '{REQ_WR_WEIGHT, 10'd1023, 5'd0,  8'sh7f,  32'sd0,        1'b0, 32'sd0},
      '{REQ_REFRESH,   10'd0,    5'd0,  8'sd0,   32'sd0,        1'b0, 32'sd0},
      '{REQ_READ,      10'd0,    5'd0,  8'sd0,   32'sd0,        1'b1, 32'sh7fffffff},
      '{REQ_READ,      10'd0,    5'd31, 8'sd0,   32'sd0,        1'b1, 32'sh80000000},
      '{REQ_ADD,       10'd0,    5'd0,  8'sd0,   32'sd0,        1'b0, 32'sd0},
      '{REQ_READ,      10'd0,    5'd0,  8'sd0,   32'sd0,        1'b0, 32'sd0},
      '{REQ_READ,      10'd0,    5'd31, 8'sd0,   32'sd0,        1'b0, 32'sd0},
      '{REQ_REMOVE,    10'd1023, 5'd0,  8'sd0,   32'sd0,        1'b0, 32'sd0},
      '{REQ_READ,      10'd0,    5'd31, 8'sd0,   32'sd0,        1'b0, 32'sd0},
      '{REQ_READ,      10'd0,    5'd0,  8'sd0,   32'sd0,        1'b0, 32'sd0},
      '{REQ_REMOVE,    10'd0,    5'd0,  8'sd0,   32'sd0,        1'b0, 32'sd0},
      '{REQ_ADD,       10'd1023, 5'd0,  8'sd0,   32'sd0,        1'b0, 32'sd0},
      '{REQ_READ,      10'd0,    5'd16, 8'sd0,   32'sd0,        1'b0, 32'sd0}
   };

   // accumulator state as the block should hold it
   logic signed [WEIGHT_W-1:0] weight_mem [FEATURES*NEURONS] = '{default: '0};
   logic signed [SUM_W-1:0]    bias_mem [NEURONS]            = '{default: '0};
   logic signed [SUM_W-1:0]    sum_mem [NEURONS]             = '{default: '0};
   read_result_type            pending_sums [$];

   // rows safe to add or remove: every weight written
   bit weight_set [FEATURES*NEURONS];
   int row_fill [FEATURES];
   int full_rows [$];

   int mismatches  = 0;
   int idle_cycles = 0;
   int burst_left  = 1;

   function automatic void apply_to_accumulator(op_word_type w);
      int              base;
      read_result_type res;
      base = int'(w.feature) * NEURONS;
      case (w.kind)
         REQ_WR_WEIGHT: begin
            if (w.feature < FEATURES && w.neuron < NEURONS)
               weight_mem[base + w.neuron] = w.weight;
         end
         REQ_WR_BIAS: begin
            if (w.neuron < NEURONS)
               bias_mem[w.neuron] = w.bias;
         end
         REQ_REFRESH: begin
            for (int j = 0; j < NEURONS; j++)
               sum_mem[j] = bias_mem[j];
         end
         REQ_ADD: begin
            if (w.feature < FEATURES)
               for (int j = 0; j < NEURONS; j++)
                  sum_mem[j] = sum_mem[j] + weight_mem[base + j];
         end
         REQ_REMOVE: begin
            if (w.feature < FEATURES)
               for (int j = 0; j < NEURONS; j++)
                  sum_mem[j] = sum_mem[j] - weight_mem[base + j];
         end
         REQ_READ: begin
            res.neuron = w.neuron;
            if (w.fixed_sum)
               res.sum = w.sum;
            else
               res.sum = (w.neuron < NEURONS) ? sum_mem[w.neuron] : '0;
            pending_sums.push_back(res);
         end
         default: ;
      endcase
   endfunction

   function automatic op_word_type make_word(logic [REQ_TYPE_W-1:0] kind, int feature,
                                             int neuron, logic signed [SUM_W-1:0] bias);
      op_word_type w;
      w           = '0;
      w.kind      = kind;
      w.feature   = FEATURE_W'(feature);
      w.neuron    = NEURON_W'(neuron);
      w.weight    = WEIGHT_W'($urandom);
      w.bias      = bias;
      return w;
   endfunction

   function automatic logic signed [SUM_W-1:0] random_bias();
      case ($urandom_range(0, 7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         default: return $urandom;
      endcase
   endfunction

   function automatic op_word_type random_word();
      op_word_type w;
      int          pick;
      w    = make_word(REQ_READ, $urandom_range(0, FEATURES - 1), $urandom, random_bias());
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         w.kind = REQ_READ;
      end else if (pick < 50) begin
         w.kind    = REQ_ADD;
         w.feature = FEATURE_W'(full_rows[$urandom_range(0, full_rows.size() - 1)]);
      end else if (pick < 65) begin
         w.kind    = REQ_REMOVE;
         w.feature = FEATURE_W'(full_rows[$urandom_range(0, full_rows.size() - 1)]);
      end else if (pick < 72) begin
         w.kind = REQ_REFRESH;
      end else if (pick < 82) begin
         w.kind = REQ_WR_BIAS;
      end else if (pick < 94) begin
         w.kind = REQ_WR_WEIGHT;
      end else begin
         w.kind = $urandom_range(0, 1) ? REQ_SPARE_7 : REQ_SPARE_6;
      end
      return w;
   endfunction

   task automatic send_word(op_word_type w);
      int idx;
      int gap;
      idx = int'(w.feature) * NEURONS + int'(w.neuron);
      if (w.kind == REQ_WR_WEIGHT && !weight_set[idx]) begin
         weight_set[idx] = 1'b1;
         row_fill[w.feature]++;
         if (row_fill[w.feature] == NEURONS)
            full_rows.push_back(w.feature);
      end
      cur_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_pending();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_sums.size() != 0);
      @(posedge clock);
   endtask

   // receiver stalls: rotate a pattern, reload it now and then
   logic [15:0] stall_pattern = '1;
   int          stall_left    = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pattern <= '1;
            1: stall_pattern <= 16'($urandom) | 16'h0001;
            default: stall_pattern <= 16'($urandom) | 16'h8421;
         endcase
         stall_left <= $urandom_range(32, 160);
      end else begin
         stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
         stall_left    <= stall_left - 1;
      end
      rsp_ready <= stall_pattern[0];
   end

   always @(posedge clock) begin : monitor
      read_result_type want;
      bit              moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_bus.valid && rsp_ready) begin
            moved = 1'b1;
            if (pending_sums.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word, expected none, got neuron %0d sum %0d",
                        $time, rsp_bus.read_neuron, rsp_bus.sum_value);
            end else begin
               want = pending_sums.pop_front();
               if (rsp_bus.read_neuron !== want.neuron) begin
                  mismatches++;
                  $display("%0t: read_neuron expected %0d got %0d",
                           $time, want.neuron, rsp_bus.read_neuron);
               end
               if (rsp_bus.sum_value !== want.sum) begin
                  mismatches++;
                  $display("%0t: sum_value of neuron %0d expected %0d got %0d",
                           $time, want.neuron, want.sum, rsp_bus.sum_value);
               end
            end
         end
         if (req_valid && req_bus.ready) begin
            moved = 1'b1;
            apply_to_accumulator(cur_word);
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles == WATCHDOG) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG);
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      op_word_type w;
      int          counted;
      int          next_pause;
      int          feat;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < NEURONS; n++)
         send_word(make_word(REQ_WR_BIAS, $urandom, n, random_bias()));
      for (int n = 0; n < NEURONS; n++) begin
         send_word(make_word(REQ_WR_WEIGHT, 0, n, $urandom));
         send_word(make_word(REQ_WR_WEIGHT, FEATURES - 1, n, $urandom));
      end

      foreach (directed_ops[i])
         send_word(directed_ops[i]);
      drain_pending();

      counted    = 0;
      next_pause = PAUSE_EVERY;
      while (counted < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) == 0) begin
            feat = $urandom_range(0, FEATURES - 1);
            for (int n = 0; n < NEURONS; n++)
               send_word(make_word(REQ_WR_WEIGHT, feat, n, $urandom));
            counted += NEURONS;
         end else begin
            w = random_word();
            send_word(w);
            if (w.kind != REQ_SPARE_6 && w.kind != REQ_SPARE_7)
               counted++;
         end
         if (counted >= next_pause) begin
            drain_pending();
            next_pause += PAUSE_EVERY;
         end
      end

      drain_pending();
      repeat (2 * NEURONS + 8) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
